// File: rtl/psm_pkg.sv
// Shared types, sequencer states and saturation helper for the planar shadow matrix block.
package psm_pkg;

  typedef logic signed [31:0] word_t;

  // One queued transaction: both edge vectors and the third plane point
  typedef struct packed {
    word_t e1x;
    word_t e1y;
    word_t e1z;
    word_t e2x;
    word_t e2y;
    word_t e2z;
    word_t p2x;
    word_t p2y;
    word_t p2z;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CROSS,
    S_MAG,
    S_NORM,
    S_SQ,
    S_SQRT,
    S_DIV,
    S_PLANE,
    S_COL
  } state_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int NUM_LIGHT   = 4;

  localparam logic signed [65:0] MAX32 = 66'sd2147483647;
  localparam logic signed [65:0] MIN32 = -66'sd2147483648;

  // Clamp a wide signed value to 32 bits signed
  function automatic word_t sat32(input logic signed [65:0] v);
    if (v > MAX32) begin
      return 32'sh7fffffff;
    end else if (v < MIN32) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// File: rtl/planar_shadow_matrix.sv
// Top level: light registers, front-end queue and back-end sequencer of the shadow matrix block.
//
// Each start transaction carries three points of a plane; the block returns the four columns of
// the planar shadow projection matrix, one per result_valid strobe, column 0 first, with
// final_column set on column 3. The receiver cannot stall: each column is on the result ports
// for exactly one cycle. One shared 32x32 multiplier and bit-serial square root and division
// set the cost of a transaction, as does the normalizing shift of the cross product; a
// degenerate triangle with a zero normal skips the root and the division. A two-entry input
// queue lets start be taken while the back end works; busy is high only while that queue is full.
module planar_shadow_matrix #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  psm_pkg::word_t  p0_x,
  input  psm_pkg::word_t  p0_y,
  input  psm_pkg::word_t  p0_z,
  input  psm_pkg::word_t  p1_x,
  input  psm_pkg::word_t  p1_y,
  input  psm_pkg::word_t  p1_z,
  input  psm_pkg::word_t  p2_x,
  input  psm_pkg::word_t  p2_y,
  input  psm_pkg::word_t  p2_z,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [7:0]      cfg_index,
  input  psm_pkg::word_t  cfg_data,
  output logic            result_valid,
  output logic [1:0]      column_index,
  output psm_pkg::word_t  elem_0,
  output psm_pkg::word_t  elem_1,
  output psm_pkg::word_t  elem_2,
  output psm_pkg::word_t  elem_3,
  output logic            final_column
);
  import psm_pkg::*;

  word_t [NUM_LIGHT-1:0] light;
  logic                  head_valid;
  item_t                 head;
  logic                  pop;

  assign cfg_ready = 1'b1;

  // Light registers; writes above the last index are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      light[0] <= '0;
      light[1] <= '0;
      light[2] <= '0;
      light[3] <= 32'(64'(1) << FRAC_BITS);
    end else if (cfg_valid && cfg_ready && cfg_index < 8'(NUM_LIGHT)) begin
      light[cfg_index[1:0]] <= cfg_data;
    end
  end

  psm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .p0_x       (p0_x),
    .p0_y       (p0_y),
    .p0_z       (p0_z),
    .p1_x       (p1_x),
    .p1_y       (p1_y),
    .p1_z       (p1_z),
    .p2_x       (p2_x),
    .p2_y       (p2_y),
    .p2_z       (p2_z),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  psm_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .light        (light),
    .result_valid (result_valid),
    .column_index (column_index),
    .elem_0       (elem_0),
    .elem_1       (elem_1),
    .elem_2       (elem_2),
    .elem_3       (elem_3),
    .final_column (final_column)
  );

endmodule

// File: rtl/psm_front.sv
// Front end: accepts plane points, forms saturated edges and queues transactions.
module psm_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  psm_pkg::word_t  p0_x,
  input  psm_pkg::word_t  p0_y,
  input  psm_pkg::word_t  p0_z,
  input  psm_pkg::word_t  p1_x,
  input  psm_pkg::word_t  p1_y,
  input  psm_pkg::word_t  p1_z,
  input  psm_pkg::word_t  p2_x,
  input  psm_pkg::word_t  p2_y,
  input  psm_pkg::word_t  p2_z,
  output logic            head_valid,
  output psm_pkg::item_t  head,
  input  logic            pop
);
  import psm_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  item_t          mem [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;
  logic           accept;
  item_t          entry;

  function automatic word_t sub_sat(input word_t a, input word_t b);
    return sat32(66'(a) - 66'(b));
  endfunction

  // Form the edges on the way in
  always_comb begin
    entry.e1x = sub_sat(p0_x, p1_x);
    entry.e1y = sub_sat(p0_y, p1_y);
    entry.e1z = sub_sat(p0_z, p1_z);
    entry.e2x = sub_sat(p1_x, p2_x);
    entry.e2y = sub_sat(p1_y, p2_y);
    entry.e2z = sub_sat(p1_z, p2_z);
    entry.p2x = p2_x;
    entry.p2y = p2_y;
    entry.p2z = p2_z;
  end

  assign busy       = (count == (PW+1)'(QUEUE_DEPTH));
  assign accept     = start && !busy;
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  // Store accepted transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wr_ptr] <= entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({accept, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/psm_back.sv
// Back end: sequencer with one shared multiplier that builds the normal and the matrix columns.
module psm_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   head_valid,
  input  psm_pkg::item_t         head,
  output logic                   pop,
  input  psm_pkg::word_t [3:0]   light,
  output logic                   result_valid,
  output logic [1:0]             column_index,
  output psm_pkg::word_t         elem_0,
  output psm_pkg::word_t         elem_1,
  output psm_pkg::word_t         elem_2,
  output psm_pkg::word_t         elem_3,
  output logic                   final_column
);
  import psm_pkg::*;

  localparam logic signed [65:0] HALF_Q = 66'(1) << (FRAC_BITS - 1);
  localparam logic [63:0] TOP_HI = 64'(1) << 30;
  localparam logic [63:0] TOP_LO = 64'(1) << 29;

  state_t                state;
  state_t                state_next;
  logic [4:0]            cnt;
  item_t                 item;
  word_t                 mul_a;
  word_t                 mul_b;
  logic signed [63:0]    prod;
  logic signed [63:0]    tmp;
  logic signed [64:0]    acc;
  logic signed [63:0]    cr   [3];
  logic [63:0]           mag  [3];
  logic                  neg  [3];
  logic [32:0]           rem  [3];
  logic [FRAC_BITS:0]    quo  [3];
  word_t                 nrm  [3];
  word_t                 dval;
  word_t                 dot;
  logic [63:0]           sq_s;
  logic [63:0]           sq_res;
  logic [31:0]           len;
  logic [63:0]           top;
  logic [63:0]           sq_bit;
  logic [63:0]           sq_try;
  logic [63:0]           sq_res_new;
  logic [63:0]           sq_s_new;
  logic [3:0]            col_idx;
  logic [1:0]            col_j;
  logic [1:0]            col_k;
  word_t                 col_e;
  logic signed [65:0]    sum_w;

  function automatic logic signed [65:0] rescale(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = v + HALF_Q;
    return t >>> FRAC_BITS;
  endfunction

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (head_valid) state_next = S_CROSS;
      S_CROSS: if (cnt == 5'd6) state_next = S_MAG;
      S_MAG:   state_next = S_NORM;
      S_NORM: begin
        if (top == '0) begin
          state_next = S_PLANE;
        end else if (top < TOP_HI && top >= TOP_LO) begin
          state_next = S_SQ;
        end
      end
      S_SQ:    if (cnt == 5'd3) state_next = S_SQRT;
      S_SQRT:  if (cnt == 5'd0) state_next = S_DIV;
      S_DIV:   if (cnt == 5'(FRAC_BITS)) state_next = S_PLANE;
      S_PLANE: if (cnt == 5'd7) state_next = S_COL;
      S_COL:   if (cnt == 5'd16) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    pop = (state == S_IDLE) && head_valid;
  end

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_CROSS: begin
        case (cnt)
          5'd0: begin mul_a = item.e1y; mul_b = item.e2z; end
          5'd1: begin mul_a = item.e1z; mul_b = item.e2y; end
          5'd2: begin mul_a = item.e1z; mul_b = item.e2x; end
          5'd3: begin mul_a = item.e1x; mul_b = item.e2z; end
          5'd4: begin mul_a = item.e1x; mul_b = item.e2y; end
          5'd5: begin mul_a = item.e1y; mul_b = item.e2x; end
          default: ;
        endcase
      end
      S_SQ: begin
        if (cnt < 5'd3) begin
          mul_a = mag[cnt[1:0]][31:0];
          mul_b = mag[cnt[1:0]][31:0];
        end
      end
      S_PLANE: begin
        case (cnt)
          5'd0: begin mul_a = nrm[0]; mul_b = item.p2x; end
          5'd1: begin mul_a = nrm[1]; mul_b = item.p2y; end
          5'd2: begin mul_a = nrm[2]; mul_b = item.p2z; end
          5'd3: begin mul_a = nrm[0]; mul_b = light[0]; end
          5'd4: begin mul_a = nrm[1]; mul_b = light[1]; end
          5'd5: begin mul_a = nrm[2]; mul_b = light[2]; end
          5'd6: begin mul_a = dval;   mul_b = light[3]; end
          default: ;
        endcase
      end
      S_COL: begin
        // Row j of the light times plane component k of the column
        if (cnt < 5'd16) begin
          mul_a = light[cnt[1:0]];
          case (cnt[3:2])
            2'd0:    mul_b = nrm[0];
            2'd1:    mul_b = nrm[1];
            2'd2:    mul_b = nrm[2];
            default: mul_b = dval;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Largest magnitude, square root step, column element
  always_comb begin
    top = mag[0];
    if (mag[1] > top) top = mag[1];
    if (mag[2] > top) top = mag[2];
    sq_bit = 64'(1) << {cnt, 1'b0};
    sq_try = sq_res + sq_bit;
    if (sq_s >= sq_try) begin
      sq_s_new   = sq_s - sq_try;
      sq_res_new = (sq_res >> 1) + sq_bit;
    end else begin
      sq_s_new   = sq_s;
      sq_res_new = sq_res >> 1;
    end
    col_idx = 4'(cnt - 5'd1);
    col_j   = col_idx[1:0];
    col_k   = col_idx[3:2];
    col_e   = sat32(((col_j == col_k) ? 66'(dot) : 66'sd0) - rescale(66'(prod)));
    sum_w   = 66'(acc) + 66'(prod);
  end

  // Hold state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      if (state != state_next) begin
        cnt <= (state_next == S_SQRT) ? 5'd31 : 5'd0;
      end else if (state == S_SQRT) begin
        cnt <= cnt - 1'b1;
      end else begin
        cnt <= cnt + 1'b1;
      end
      if (state == S_COL && cnt != 5'd0 && col_j == 2'd3) begin
        result_valid <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (state)
      S_IDLE: begin
        if (head_valid) item <= head;
      end
      S_CROSS: begin
        case (cnt)
          5'd1, 5'd3, 5'd5: tmp <= prod;
          5'd2: cr[0] <= tmp - prod;
          5'd4: cr[1] <= tmp - prod;
          5'd6: cr[2] <= tmp - prod;
          default: ;
        endcase
      end
      S_MAG: begin
        for (int i = 0; i < 3; i++) begin
          neg[i] <= cr[i][63];
          mag[i] <= cr[i][63] ? (64'd0 - 64'(cr[i])) : 64'(cr[i]);
        end
      end
      S_NORM: begin
        if (top == '0) begin
          for (int i = 0; i < 3; i++) nrm[i] <= '0;
        end else if (top >= TOP_HI) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
        end else if (top < TOP_LO) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
        end
        acc <= '0;
      end
      S_SQ: begin
        if (cnt != 5'd0) acc <= acc + 65'(prod);
        if (cnt == 5'd3) begin
          sq_s   <= 64'(sum_w);
          sq_res <= '0;
        end
      end
      S_SQRT: begin
        sq_s   <= sq_s_new;
        sq_res <= sq_res_new;
        if (cnt == 5'd0) len <= sq_res_new[31:0];
      end
      S_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (cnt == 5'd0) begin
            if (mag[i][32:0] >= {1'b0, len}) begin
              quo[i] <= (FRAC_BITS+1)'(1);
              rem[i] <= mag[i][32:0] - {1'b0, len};
            end else begin
              quo[i] <= '0;
              rem[i] <= mag[i][32:0];
            end
          end else if ({rem[i][31:0], 1'b0} >= {1'b0, len}) begin
            quo[i] <= {quo[i][FRAC_BITS-1:0], 1'b1};
            rem[i] <= {rem[i][31:0], 1'b0} - {1'b0, len};
            if (cnt == 5'(FRAC_BITS)) begin
              nrm[i] <= neg[i] ? -32'({quo[i][FRAC_BITS-1:0], 1'b1})
                                : 32'({quo[i][FRAC_BITS-1:0], 1'b1});
            end
          end else begin
            quo[i] <= {quo[i][FRAC_BITS-1:0], 1'b0};
            rem[i] <= {rem[i][31:0], 1'b0};
            if (cnt == 5'(FRAC_BITS)) begin
              nrm[i] <= neg[i] ? -32'({quo[i][FRAC_BITS-1:0], 1'b0})
                                : 32'({quo[i][FRAC_BITS-1:0], 1'b0});
            end
          end
        end
        acc <= '0;
      end
      S_PLANE: begin
        if (cnt == 5'd0) begin
          acc <= '0;
        end else if (cnt == 5'd3) begin
          dval <= sat32(rescale(-sum_w));
          acc  <= '0;
        end else if (cnt == 5'd7) begin
          dot <= sat32(rescale(sum_w));
        end else begin
          acc <= acc + 65'(prod);
        end
      end
      S_COL: begin
        if (cnt != 5'd0) begin
          case (col_j)
            2'd0: elem_0 <= col_e;
            2'd1: elem_1 <= col_e;
            2'd2: elem_2 <= col_e;
            default: begin
              elem_3       <= col_e;
              column_index <= col_k;
              final_column <= (col_k == 2'd3);
            end
          endcase
        end
      end
      default: ;
    endcase
  end

endmodule

// File: dv/tb_planar_shadow_matrix.sv
// Self-checking testbench for the planar shadow matrix block.
module tb_planar_shadow_matrix;
  import psm_pkg::*;

  localparam int FRAC = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 300;
  localparam int IDX_LX = 0;
  localparam int IDX_LY = 1;
  localparam int IDX_LZ = 2;
  localparam int IDX_LW = 3;
  localparam int IDX_BAD = 7;
  localparam logic signed [31:0] WMAX = 32'sh7fffffff;
  localparam logic signed [31:0] WMIN = 32'sh80000000;
  localparam logic signed [31:0] ONE_Q = 32'sh00010000;

  typedef struct packed {
    logic [1:0] col;
    word_t e0;
    word_t e1;
    word_t e2;
    word_t e3;
    logic fin;
  } column_t;

  typedef struct {
    word_t pt[9];
    logic has_check;
    word_t col0_e0;
  } triangle_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  word_t p0_x = '0, p0_y = '0, p0_z = '0;
  word_t p1_x = '0, p1_y = '0, p1_z = '0;
  word_t p2_x = '0, p2_y = '0, p2_z = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  word_t cfg_data = '0;
  logic result_valid;
  logic [1:0] column_index;
  word_t elem_0, elem_1, elem_2, elem_3;
  logic final_column;

  planar_shadow_matrix dut (.*);

  always #5 clk = ~clk;

  // Predictor copy of the light registers
  longint light_q[4];
  column_t column_q[$];
  int mismatches = 0;
  int idle_cycles = 0;
  logic timed_out = 1'b0;

  function automatic longint clamp32(longint v);
    if (v > longint'(WMAX)) return longint'(WMAX);
    if (v < longint'(WMIN)) return longint'(WMIN);
    return v;
  endfunction

  // Round half up after dropping the fraction bits
  function automatic longint round_frac(longint v);
    return (v + (longint'(1) << (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic longint root_floor(longint unsigned s);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > s) bit_v >>= 2;
    while (bit_v != 0) begin
      if (s >= res + bit_v) begin
        s -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return longint'(res);
  endfunction

  // Compute the four shadow matrix columns for one triangle
  function automatic void predict_shadow(input word_t pt[9]);
    longint p[3][3], ea[3], eb[3], cr[3], plane[4], acc, dotv, diag;
    longint unsigned mag[3], top, sum, len, q;
    logic neg[3];
    column_t c;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) p[i][j] = longint'(pt[i*3+j]);
    for (int j = 0; j < 3; j++) begin
      ea[j] = clamp32(p[0][j] - p[1][j]);
      eb[j] = clamp32(p[1][j] - p[2][j]);
    end
    cr[0] = ea[1]*eb[2] - ea[2]*eb[1];
    cr[1] = ea[2]*eb[0] - ea[0]*eb[2];
    cr[2] = ea[0]*eb[1] - ea[1]*eb[0];
    top = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = cr[i] < 0;
      mag[i] = neg[i] ? -cr[i] : cr[i];
      if (mag[i] > top) top = mag[i];
    end
    if (top == 0) begin
      for (int i = 0; i < 3; i++) plane[i] = 0;
    end else begin
      while (top >= (64'd1 << 30)) begin
        top >>= 1;
        for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      while (top < (64'd1 << 29)) begin
        top <<= 1;
        for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      sum = mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2];
      len = root_floor(sum);
      for (int i = 0; i < 3; i++) begin
        q = (mag[i] << FRAC) / len;
        plane[i] = neg[i] ? -longint'(q) : longint'(q);
      end
    end
    acc = plane[0]*p[2][0] + plane[1]*p[2][1] + plane[2]*p[2][2];
    plane[3] = clamp32(round_frac(-acc));
    acc = plane[0]*light_q[0] + plane[1]*light_q[1] + plane[2]*light_q[2]
        + plane[3]*light_q[3];
    dotv = clamp32(round_frac(acc));
    for (int k = 0; k < 4; k++) begin
      c.col = k[1:0];
      diag = (k == 0) ? dotv : 0;
      c.e0 = word_t'(clamp32(diag - round_frac(light_q[0]*plane[k])));
      diag = (k == 1) ? dotv : 0;
      c.e1 = word_t'(clamp32(diag - round_frac(light_q[1]*plane[k])));
      diag = (k == 2) ? dotv : 0;
      c.e2 = word_t'(clamp32(diag - round_frac(light_q[2]*plane[k])));
      diag = (k == 3) ? dotv : 0;
      c.e3 = word_t'(clamp32(diag - round_frac(light_q[3]*plane[k])));
      c.fin = (k == 3);
      column_q.push_back(c);
    end
  endfunction

  // Compare each column strobe with the oldest expectation
  always @(posedge clk) begin
    column_t got, want;
    if (!rst && result_valid) begin
      got = '{column_index, elem_0, elem_1, elem_2, elem_3, final_column};
      if (column_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected column %p", got);
      end else begin
        want = column_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("column exp %p got %p", want, got);
        end
      end
    end
  end

  // Watchdog: count cycles with no accepted transaction, light write or column strobe
  always @(posedge clk) begin
    if (rst || result_valid || (start && !busy) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out <= 1'b1;
      $display("planar_shadow_matrix: mismatch");
      $finish;
    end
  end

  int burst_left = 0;

  // Drive one triangle, holding start until it is taken; drop start only in a gap
  task automatic send_triangle(input word_t pt[9]);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    {p0_x, p0_y, p0_z} <= {pt[0], pt[1], pt[2]};
    {p1_x, p1_y, p1_z} <= {pt[3], pt[4], pt[5]};
    {p2_x, p2_y, p2_z} <= {pt[6], pt[7], pt[8]};
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_shadow(pt);
  endtask

  // Drop start, wait for all columns to drain, then let the pipeline settle
  task automatic drain_block();
    start <= 1'b0;
    while (column_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_light(input int idx, input word_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx[7:0];
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < 4) light_q[idx] = longint'(val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic word_t rand_coord();
    case ($urandom_range(0, 5))
      0: return word_t'($urandom());
      1: return $urandom_range(0, 1) ? WMAX : WMIN;
      default: return word_t'($signed($urandom_range(0, 20'hfffff)) - 32'sh80000);
    endcase
  endfunction

  task automatic random_phase(input int count);
    word_t pt[9];
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 9; i++) pt[i] = rand_coord();
      // Make some triangles degenerate by repeating or lining up points
      if ($urandom_range(0, 9) == 0) for (int i = 0; i < 3; i++) pt[3+i] = pt[i];
      if ($urandom_range(0, 15) == 0)
        for (int i = 0; i < 3; i++) pt[6+i] = word_t'(2*longint'(pt[3+i]) - pt[i]);
      send_triangle(pt);
    end
  endtask

  triangle_row_t rows[$];

  initial begin
    triangle_row_t r;
    word_t w[4];
    light_q = '{0, 0, 0, longint'(ONE_Q)};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table; col0 elem_0 is known only where the normal is zero
    r.has_check = 1'b1; r.col0_e0 = '0;
    r.pt = '{default: '0}; rows.push_back(r);
    r.pt = '{default: WMAX}; rows.push_back(r);
    r.pt = '{default: WMIN}; rows.push_back(r);
    r.has_check = 1'b0;
    r.pt = '{0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q, 0}; rows.push_back(r);
    r.pt = '{0, 0, ONE_Q, ONE_Q, 0, ONE_Q, 0, ONE_Q, ONE_Q}; rows.push_back(r);
    r.pt = '{WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, 0, 0, 0}; rows.push_back(r);
    r.pt = '{WMIN, 0, 0, 0, WMAX, 0, 0, 0, WMIN}; rows.push_back(r);
    r.pt = '{1, 0, 0, 0, 1, 0, 0, 0, 1}; rows.push_back(r);
    r.pt = '{-1, -1, -1, WMAX, 5, WMIN, 3, WMAX, 7}; rows.push_back(r);
    foreach (rows[i]) begin
      send_triangle(rows[i].pt);
      if (rows[i].has_check && column_q[$-3].e0 !== rows[i].col0_e0) begin
        mismatches++;
        $display("table row %0d exp %0d", i, rows[i].col0_e0);
      end
    end
    drain_block();

    // Light settings: extremes, directional, out-of-range index
    write_light(IDX_LX, WMAX);
    write_light(IDX_LY, WMIN);
    write_light(IDX_LZ, ONE_Q);
    write_light(IDX_LW, '0);
    write_light(IDX_BAD, 32'sh1234);
    random_phase(40);
    drain_block();
    write_light(IDX_LX, WMIN);
    write_light(IDX_LY, WMAX);
    write_light(IDX_LZ, WMIN);
    write_light(IDX_LW, WMAX);
    random_phase(40);
    for (int ph = 0; ph < 4; ph++) begin
      drain_block();
      for (int i = 0; i < 4; i++) w[i] = word_t'($urandom_range(0, 2) == 0
          ? $urandom() : $signed($urandom_range(0, 20'hfffff)) - 32'sh80000);
      write_light(IDX_LX, w[0]);
      write_light(IDX_LY, w[1]);
      write_light(IDX_LZ, w[2]);
      write_light(IDX_LW, (ph == 0) ? ONE_Q : w[3]);
      random_phase(30);
    end
    drain_block();

    if (mismatches == 0) begin
      $display("planar_shadow_matrix: match");
    end else begin
      $display("planar_shadow_matrix: mismatch");
    end
    $finish;
  end

endmodule
